[sv/bsws_pkg.sv]
// Shared types and constants for the bounded stack with search.
// No dependencies; every other file of the block imports this package.
package bsws_pkg;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 32;
  localparam int CAP_W    = 7;
  localparam int IDX_W    = 7;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_FIND = 2'd2;

  localparam cap_t CAP_RESET = 7'd64;
  localparam idx_t IDX_NONE  = 7'h7F;

endpackage

[sv/bsws_if.sv]
// Channel interfaces of the bounded stack with search: request, response, configuration.
// Depends on bsws_pkg for the field types.
interface bsws_req_if import bsws_pkg::*; ();
  logic    valid;
  logic    ready;
  op_t     operation;
  handle_t handle;

  modport source (output valid, output operation, output handle, input ready);
  modport sink   (input valid, input operation, input handle, output ready);
endinterface

interface bsws_rsp_if import bsws_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          accepted;
  handle_t       popped_handle;
  logic signed [IDX_W-1:0] found_index;
  cap_t          occupancy;
  logic          is_full;
  logic          is_empty;

  modport source (output valid, output accepted, output popped_handle, output found_index,
                  output occupancy, output is_full, output is_empty, input ready);
  modport sink   (input valid, input accepted, input popped_handle, input found_index,
                  input occupancy, input is_full, input is_empty, output ready);
endinterface

interface bsws_cfg_if import bsws_pkg::*; ();
  logic valid;
  logic ready;
  cap_t capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[sv/bounded_stack_with_search.sv]
// Bounded LIFO stack of handles with a linear search, one memory and one shared comparator.
// Depends on bsws_pkg and the channel interfaces in bsws_if.sv.
//
//   channel | dir | beat carries
//   req     | in  | operation, handle
//   rsp     | out | accepted, popped_handle, found_index, occupancy, is_full, is_empty
//   cfg     | in  | capacity (always ready)
//
// Push goes from the request beat straight to write-back; pop passes through one extra
// state for its memory read. Find scans upward from the bottom entry; the comparator checks one
// stored entry per cycle behind the registered memory read, and a miss scans every entry.
// A find with a null handle or on an empty stack, and a pop of an empty stack, go straight to write-back.
// One item at a time: req.ready is low from the request beat until its result is in the
// response register; a stalled response holds the next result back in the sequencer.
// Synchronous reset empties the stack and sets capacity to 64; no clearing pass.
module bounded_stack_with_search import bsws_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  bsws_req_if.sink   req,
  bsws_rsp_if.source rsp,
  bsws_cfg_if.sink   cfg
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [HANDLE_WIDTH-1:0] mem [DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic [HANDLE_WIDTH-1:0] req_h;

  logic [1:0]              state, state_next;
  logic [CW-1:0]           top, top_next;
  logic [CW-1:0]           scan_addr, scan_addr_next;
  logic [CW-1:0]           rd_idx, rd_idx_next;
  logic                    rd_vld, rd_vld_next;
  logic [HANDLE_WIDTH-1:0] key, key_next;
  logic                    res_acc, res_acc_next;
  logic [HANDLE_WIDTH-1:0] res_pop, res_pop_next;
  idx_t                    res_idx, res_idx_next;
  cap_t                    capacity;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [CMPW-1:0]         cap_eff;
  logic [CMPW-1:0]         top_ext;
  logic                    req_beat;
  logic                    rsp_load;

  assign req_h    = HANDLE_WIDTH'(req.handle);
  assign req.ready = (state == S_IDLE);
  assign req_beat  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign top_ext   = CMPW'(top);
  assign rsp_load  = (state == S_WB) && (!rsp.valid || rsp.ready);

  // Clamp capacity: zero acts as one, anything past DEPTH acts as DEPTH.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity) > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = CMPW'(capacity);
    end
  end

  always_comb begin
    state_next     = state;
    top_next       = top;
    scan_addr_next = scan_addr;
    rd_idx_next    = rd_idx;
    rd_vld_next    = 1'b0;
    key_next       = key;
    res_acc_next   = res_acc;
    res_pop_next   = res_pop;
    res_idx_next   = res_idx;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = top[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req_beat) begin
          res_acc_next = 1'b0;
          res_pop_next = '0;
          res_idx_next = IDX_NONE;
          key_next     = req_h;
          state_next   = S_WB;
          case (req.operation)
            OP_PUSH: begin
              if (req_h != '0 && top_ext < cap_eff && top_ext < DEPTH_C) begin
                mem_we       = 1'b1;
                top_next     = top + CW'(1);
                res_acc_next = 1'b1;
              end
            end
            OP_POP: begin
              if (top != '0) begin
                mem_re       = 1'b1;
                mem_addr     = AW'(top - CW'(1));
                top_next     = top - CW'(1);
                res_acc_next = 1'b1;
                state_next   = S_POP;
              end
            end
            OP_FIND: begin
              if (req_h != '0 && top != '0) begin
                scan_addr_next = '0;
                state_next     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_pop_next = rd_data;
        state_next   = S_WB;
      end
      S_SCAN: begin
        mem_addr = scan_addr[AW-1:0];
        // Compare the entry read last cycle while the next read goes out.
        if (rd_vld && rd_data == key) begin
          res_acc_next = 1'b1;
          res_idx_next = IDX_W'(rd_idx);
          state_next   = S_WB;
        end else if (scan_addr < top) begin
          mem_re         = 1'b1;
          rd_vld_next    = 1'b1;
          rd_idx_next    = scan_addr;
          scan_addr_next = scan_addr + CW'(1);
        end else if (!rd_vld) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= req_h;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      top      <= '0;
      rd_vld   <= 1'b0;
      capacity <= CAP_RESET;
    end else begin
      state  <= state_next;
      top    <= top_next;
      rd_vld <= rd_vld_next;
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    rd_idx    <= rd_idx_next;
    key       <= key_next;
    res_acc   <= res_acc_next;
    res_pop   <= res_pop_next;
    res_idx   <= res_idx_next;
  end

  // Response register: load a finished result, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.accepted      <= res_acc;
      rsp.popped_handle <= HANDLE_W'(res_pop);
      rsp.found_index   <= res_idx;
      rsp.occupancy     <= CAP_W'(top);
      rsp.is_full       <= (top_ext >= cap_eff);
      rsp.is_empty      <= (top == '0);
    end
  end

endmodule

[sv/bsws_checker.sv]
// Port-level checks for bounded_stack_with_search, attached by the bind below.
// Depends on bsws_pkg and the top level's channel interfaces.
module bsws_checker import bsws_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input logic    accepted,
  input handle_t popped_handle,
  input idx_t    found_index,
  input cap_t    occupancy,
  input logic    is_empty
);

  // Hold a stalled response beat.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_pop_acc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && popped_handle != '0 |-> accepted && found_index == IDX_NONE)
    else $error("popped handle without a successful pop");

  a_find_acc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found_index != IDX_NONE |-> accepted && popped_handle == '0)
    else $error("found index without a successful find");

endmodule

bind bounded_stack_with_search bsws_checker u_bsws_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .accepted      (rsp.accepted),
  .popped_handle (rsp.popped_handle),
  .found_index   (rsp.found_index),
  .occupancy     (rsp.occupancy),
  .is_empty      (rsp.is_empty)
);
